FILE: rtl/sms_pkg.sv
package sms_pkg;

    // Fixed field widths of the block's ports.
    localparam int unsigned IDX_W   = 10;
    localparam int unsigned DIM_W   = 11;
    localparam int unsigned VALUE_W = 32;

    // Largest dimension a configuration write can set; larger writes saturate.
    localparam logic [DIM_W-1:0] MAX_DIM = DIM_W'(1024);
    localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(1024);

    localparam int unsigned DEFAULT_CAPACITY = 256;

    typedef enum logic [1:0] {
        OP_READ      = 2'd0,
        OP_MODIFY    = 2'd1,
        OP_TRANSPOSE = 2'd2,
        OP_NOP       = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_RANGE = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    localparam logic [1:0] CFG_NUM_ROWS = 2'd0;
    localparam logic [1:0] CFG_NUM_COLS = 2'd1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_LAST,
        S_COMMIT,
        S_FINISH
    } state_t;

    // One slot of the coordinate table, kept in the original orientation.
    typedef struct packed {
        logic                      valid;
        logic [IDX_W-1:0]          row;
        logic [IDX_W-1:0]          col;
        logic signed [VALUE_W-1:0] value;
    } entry_t;

endpackage

FILE: rtl/sms_table.sv
module sms_table #(
    parameter int unsigned DEPTH = sms_pkg::DEFAULT_CAPACITY,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic            clk,
    input  logic            wr_en,
    input  logic [AW-1:0]   wr_addr,
    input  sms_pkg::entry_t wr_data,
    input  logic [AW-1:0]   rd_addr,
    output sms_pkg::entry_t rd_data
);
    import sms_pkg::*;

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    // Simple dual-port array: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/sparse_matrix_store.sv
// Coordinate-list sparse matrix store for signed 32-bit elements.
// Input channel (in_valid/in_ready) carries one word per operation: op selects
// read, modify or transpose, row and col give the position in the current
// orientation, and value is the new element for a modify (zero deletes it).
// Output channel (out_valid/out_ready) returns exactly one word per input word:
// the element read or the old element, a status code, and the dimensions.
// Read and modify of an in-range position scan the whole table, one slot per
// cycle through the single read port, and then commit. Transpose, unused codes
// and out-of-range positions go from the check straight to the finish state.
// A new word is accepted in the cycle after the result is registered, so the
// block takes no new word while it is still working on the last one.
// The result sits in an output register; the block goes on to accept the next
// word while it waits, and only stalls, holding its own result in the finish
// state, when the output register is still occupied.
// After reset the block runs a clearing pass over every slot of the table
// with in_ready low; configuration writes (cfg_we, cfg_index, cfg_data) are
// accepted at any time, and are meant to be made while the block is idle.
// Dimension writes above 1024 saturate to 1024.
module sparse_matrix_store #(
    parameter int unsigned CAPACITY = sms_pkg::DEFAULT_CAPACITY
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [1:0]                         cfg_index,
    input  logic [sms_pkg::DIM_W-1:0]          cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [1:0]                         op,
    input  logic [sms_pkg::IDX_W-1:0]          row,
    input  logic [sms_pkg::IDX_W-1:0]          col,
    input  logic signed [sms_pkg::VALUE_W-1:0] value,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [sms_pkg::VALUE_W-1:0] result_value,
    output logic [1:0]                         status,
    output logic [sms_pkg::DIM_W-1:0]          lines,
    output logic [sms_pkg::DIM_W-1:0]          columns
);
    import sms_pkg::*;

    localparam int unsigned AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
    localparam logic [AW-1:0]    LAST_ADDR = AW'(CAPACITY - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(CAPACITY);

    state_t state_reg, state_next;

    logic [DIM_W-1:0] num_rows_reg, num_cols_reg;
    logic [DIM_W-1:0] cfg_sat;

    // Operation held for the whole sequence.
    op_t                       op_reg;
    logic [IDX_W-1:0]          row_reg, col_reg;
    logic signed [VALUE_W-1:0] value_reg;
    logic                      transposed_reg;
    logic [CNT_W-1:0]          entry_count_reg, entry_count_next;

    // Scan bookkeeping.
    logic [AW-1:0]             scan_addr_reg, scan_addr_next;
    logic                      cmp_valid_reg, cmp_valid_next;
    logic [AW-1:0]             cmp_addr_reg, cmp_addr_next;
    logic                      match_found_reg, match_found_next;
    logic [AW-1:0]             match_slot_reg, match_slot_next;
    logic signed [VALUE_W-1:0] match_value_reg, match_value_next;
    logic                      free_found_reg, free_found_next;
    logic [AW-1:0]             free_slot_reg, free_slot_next;

    // Pending result and output register.
    logic signed [VALUE_W-1:0] res_value_reg, res_value_next;
    status_t                   res_status_reg, res_status_next;
    logic                      out_valid_reg, out_valid_next;
    logic signed [VALUE_W-1:0] result_value_reg;
    status_t                   status_reg;
    logic [DIM_W-1:0]          lines_reg, columns_reg;
    logic                      load_out;

    // Table port.
    logic         tbl_wr_en;
    logic [AW-1:0] tbl_wr_addr;
    entry_t       tbl_wr_data;
    entry_t       tbl_rd_data;

    logic [DIM_W-1:0] lines_now, columns_now;
    logic             range_ok;
    logic [IDX_W-1:0] key_row, key_col;
    logic             rd_hit, rd_free;
    logic             accept;

    sms_table #(
        .DEPTH (CAPACITY)
    ) u_table (
        .clk     (clk),
        .wr_en   (tbl_wr_en),
        .wr_addr (tbl_wr_addr),
        .wr_data (tbl_wr_data),
        .rd_addr (scan_addr_reg),
        .rd_data (tbl_rd_data)
    );

    // Dimensions and the stored key follow the orientation flag.
    assign lines_now   = transposed_reg ? num_cols_reg : num_rows_reg;
    assign columns_now = transposed_reg ? num_rows_reg : num_cols_reg;
    assign range_ok    = ({1'b0, row_reg} < lines_now) && ({1'b0, col_reg} < columns_now);
    assign key_row     = transposed_reg ? col_reg : row_reg;
    assign key_col     = transposed_reg ? row_reg : col_reg;

    // The shared compare unit looks at one slot per cycle.
    assign rd_hit  = cmp_valid_reg && tbl_rd_data.valid
                     && (tbl_rd_data.row == key_row) && (tbl_rd_data.col == key_col);
    assign rd_free = cmp_valid_reg && !tbl_rd_data.valid;

    assign cfg_sat = (cfg_data > MAX_DIM) ? MAX_DIM : cfg_data;
    assign accept  = in_valid && in_ready;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (scan_addr_reg == LAST_ADDR)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if ((op_reg == OP_READ || op_reg == OP_MODIFY) && range_ok)
                begin
                    state_next = S_SCAN;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_SCAN:
            begin
                if (scan_addr_reg == LAST_ADDR)
                begin
                    state_next = S_LAST;
                end
            end
            S_LAST:   state_next = S_COMMIT;
            S_COMMIT: state_next = S_FINISH;
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_CLEAR;
        endcase
    end

    // Outputs of the sequencer: table port, scan bookkeeping and results.
    always_comb
    begin
        in_ready         = (state_reg == S_IDLE);
        load_out         = 1'b0;
        tbl_wr_en        = 1'b0;
        tbl_wr_addr      = scan_addr_reg;
        tbl_wr_data      = '0;
        scan_addr_next   = scan_addr_reg;
        cmp_valid_next   = 1'b0;
        cmp_addr_next    = cmp_addr_reg;
        match_found_next = match_found_reg;
        match_slot_next  = match_slot_reg;
        match_value_next = match_value_reg;
        free_found_next  = free_found_reg;
        free_slot_next   = free_slot_reg;
        res_value_next   = res_value_reg;
        res_status_next  = res_status_reg;
        entry_count_next = entry_count_reg;

        if (rd_hit)
        begin
            match_found_next = 1'b1;
            match_slot_next  = cmp_addr_reg;
            match_value_next = tbl_rd_data.value;
        end
        // Keep the lowest free slot, as an insert takes the first one.
        if (rd_free && !free_found_reg)
        begin
            free_found_next = 1'b1;
            free_slot_next  = cmp_addr_reg;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                tbl_wr_en      = 1'b1;
                scan_addr_next = scan_addr_reg + 1'b1;
            end
            S_IDLE:
            begin
            end
            S_CHECK:
            begin
                scan_addr_next   = '0;
                match_found_next = 1'b0;
                free_found_next  = 1'b0;
                res_value_next   = '0;
                if ((op_reg == OP_READ || op_reg == OP_MODIFY) && !range_ok)
                begin
                    res_status_next = STAT_RANGE;
                end
                else
                begin
                    res_status_next = STAT_OK;
                end
            end
            S_SCAN:
            begin
                scan_addr_next = scan_addr_reg + 1'b1;
                cmp_valid_next = 1'b1;
                cmp_addr_next  = scan_addr_reg;
            end
            S_LAST:
            begin
            end
            S_COMMIT:
            begin
                res_status_next = STAT_OK;
                res_value_next  = match_found_reg ? match_value_reg : '0;
                if (op_reg == OP_MODIFY)
                begin
                    priority if (match_found_reg)
                    begin
                        tbl_wr_en   = 1'b1;
                        tbl_wr_addr = match_slot_reg;
                        if (value_reg == '0)
                        begin
                            tbl_wr_data      = '0;
                            entry_count_next = entry_count_reg - 1'b1;
                        end
                        else
                        begin
                            tbl_wr_data = '{valid: 1'b1, row: key_row, col: key_col,
                                            value: value_reg};
                        end
                    end
                    else if (value_reg != '0)
                    begin
                        if (entry_count_reg >= FULL_CNT || !free_found_reg)
                        begin
                            res_status_next = STAT_FULL;
                        end
                        else
                        begin
                            tbl_wr_en        = 1'b1;
                            tbl_wr_addr      = free_slot_reg;
                            tbl_wr_data      = '{valid: 1'b1, row: key_row, col: key_col,
                                                 value: value_reg};
                            entry_count_next = entry_count_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        // Deleting an absent element changes nothing.
                    end
                end
            end
            S_FINISH:
            begin
                load_out = !out_valid_reg || out_ready;
            end
            default:
            begin
            end
        endcase

        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            num_rows_reg    <= DIM_RESET;
            num_cols_reg    <= DIM_RESET;
            transposed_reg  <= 1'b0;
            entry_count_reg <= '0;
            scan_addr_reg   <= '0;
            cmp_valid_reg   <= 1'b0;
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            entry_count_reg <= entry_count_next;
            scan_addr_reg   <= scan_addr_next;
            cmp_valid_reg   <= cmp_valid_next;
            match_found_reg <= match_found_next;
            free_found_reg  <= free_found_next;
            out_valid_reg   <= out_valid_next;
            if (cfg_we && cfg_index == CFG_NUM_ROWS)
            begin
                num_rows_reg <= cfg_sat;
            end
            if (cfg_we && cfg_index == CFG_NUM_COLS)
            begin
                num_cols_reg <= cfg_sat;
            end
            if (accept && op_t'(op) == OP_TRANSPOSE)
            begin
                transposed_reg <= !transposed_reg;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cmp_addr_reg    <= cmp_addr_next;
        match_slot_reg  <= match_slot_next;
        match_value_reg <= match_value_next;
        free_slot_reg   <= free_slot_next;
        res_value_reg   <= res_value_next;
        res_status_reg  <= res_status_next;
        if (accept)
        begin
            op_reg    <= op_t'(op);
            row_reg   <= row;
            col_reg   <= col;
            value_reg <= value;
        end
        if (load_out)
        begin
            result_value_reg <= res_value_reg;
            status_reg       <= res_status_reg;
            lines_reg        <= lines_now;
            columns_reg      <= columns_now;
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_value = result_value_reg;
    assign status       = status_reg;
    assign lines        = lines_reg;
    assign columns      = columns_reg;

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        entry_count_reg <= FULL_CNT)
        else $error("entry count above capacity");

    a_count_only_in_commit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_COMMIT |=> $stable(entry_count_reg))
        else $error("entry count changed outside commit");

    a_flip_only_on_transpose: assert property (@(posedge clk) disable iff (!rst_n)
        !(accept && op_t'(op) == OP_TRANSPOSE) |=> $stable(transposed_reg))
        else $error("orientation changed without a transpose");

    a_free_slot_found: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_COMMIT && op_reg == OP_MODIFY && !match_found_reg
         && value_reg != '0 && entry_count_reg < FULL_CNT) |-> free_found_reg)
        else $error("scan missed a free slot while the table is not full");

endmodule
